### src/pbtd_pkg.sv
package pbtd_pkg;

	localparam int TIME_W    = 32;
	localparam int PTIME_W   = 16;
	localparam int BSIZE_W   = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [BSIZE_W-1:0] BSIZE_RST = 7'd64;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the incoming item
		logic pop;       // retire the oldest held entry
		logic push;      // queue the latched item
		logic out_load;  // capture the result into the output register
	} pbtd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;     // no entries held
		logic head_le;   // oldest finish time is at or before the arrival time
		logic full;      // occupancy has reached the capacity
	} pbtd_stat_t;

endpackage

### src/pbtd_datapath.sv
module pbtd_datapath
	import pbtd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [BSIZE_W-1:0]  cfg_wdata,
	input  logic [TIME_W-1:0]   arrive_ts,
	input  logic [PTIME_W-1:0]  service_len,
	input  pbtd_cmd_t           cmd,
	output pbtd_stat_t          stat,
	output logic                dropped,
	output logic [TIME_W-1:0]   start_ts
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam int CW = (OW > BSIZE_W) ? OW : BSIZE_W;

	logic [BSIZE_W-1:0] bsize_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [OW-1:0]      occ_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  arr_q;
	logic [PTIME_W-1:0] ptime_q;
	logic [TIME_W-1:0]  rd_q;
	logic               dropped_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  ring_q [DEPTH];

	logic [AW-1:0]      head_next;
	logic [AW-1:0]      tail_next;
	logic [AW-1:0]      raddr;
	logic [CW-1:0]      cap;
	logic [TIME_W-1:0]  start_val;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  fin;

	// ring pointers wrap at the depth, which need not be a power of two
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign raddr     = cmd.pop ? head_next : head_q;

	// capacity is the programmed size clipped at the ring depth
	assign cap = (CW'(bsize_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(bsize_q);

	// start and saturated finish time of the latched item
	assign start_val = (occ_q == '0) ? arr_q : last_q;
	assign sum       = {1'b0, start_val} + (TIME_W + 1)'(ptime_q);
	assign fin       = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

	assign stat.empty   = (occ_q == '0);
	assign stat.head_le = (rd_q <= arr_q);
	assign stat.full    = (CW'(occ_q) >= cap);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= BSIZE_RST;
		end else if (cfg_we) begin
			bsize_q <= cfg_wdata;
		end
	end

	// ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			last_q <= '0;
		end else if (cmd.pop) begin
			head_q <= head_next;
			occ_q  <= occ_q - 1'b1;
		end else if (cmd.push) begin
			tail_q <= tail_next;
			occ_q  <= occ_q + 1'b1;
			last_q <= fin;
		end
	end

	// finish time memory; read data tracks the head entry, write forwarded
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[tail_q] <= fin;
		end
		if (cmd.push && (tail_q == raddr)) begin
			rd_q <= fin;
		end else begin
			rd_q <= ring_q[raddr];
		end
	end

	// latch the item and hold the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arr_q   <= arrive_ts;
			ptime_q <= service_len;
		end
		if (cmd.out_load) begin
			dropped_q <= stat.full;
			start_q   <= stat.full ? '0 : start_val;
		end
	end

	assign dropped  = dropped_q;
	assign start_ts = start_q;

endmodule

### src/pbtd_ctrl.sv
module pbtd_ctrl
	import pbtd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pbtd_stat_t stat,
	output pbtd_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_RETIRE
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// retire one entry a cycle, then decide once the output register is free
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid && in_ready_q;
			end
			S_RETIRE: begin
				if (!stat.empty && stat.head_le) begin
					cmd.pop = 1'b1;
				end else if (out_free) begin
					cmd.push     = !stat.full;
					cmd.out_load = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q    <= S_RETIRE;
						in_ready_q <= 1'b0;
					end
				end
				S_RETIRE: begin
					if (cmd.out_load) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

### src/packet_buffer_tail_drop_timing.sv
// Tail-drop packet buffer timing.
// Input channel (in_valid/in_ready) takes one packet item: arrive_ts and
// service_len. Output channel (out_valid/out_ready) returns one result item
// per packet: dropped, and start_ts (0 for a dropped packet).
// cfg_we/cfg_wdata write buffer_size (0..127); it is clipped at DEPTH. Write
// it only while the block is idle.
// After the input item is taken, the held entries that retire for this
// packet are popped, then the result is loaded into the output register. The
// retire loop pops one entry per cycle out of the finish time memory, whose
// registered read port always holds the current head entry.
// Only one packet is in progress at a time; in_ready returns the cycle after
// the result is loaded, so a new item is taken while that result waits.
// Reset clears the ring pointers, occupancy and last finish time and sets
// buffer_size to 64; the memory itself needs no clearing.
// If the receiver stalls, the next packet is retired and then holds until
// the output register frees up; nothing is lost.
module packet_buffer_tail_drop_timing
	import pbtd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BSIZE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  arrive_ts,
	input  logic [PTIME_W-1:0] service_len,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               dropped,
	output logic [TIME_W-1:0]  start_ts
);

	pbtd_cmd_t  cmd;
	pbtd_stat_t stat;

	pbtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pbtd_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.arrive_ts   (arrive_ts),
		.service_len (service_len),
		.cmd         (cmd),
		.stat        (stat),
		.dropped     (dropped),
		.start_ts    (start_ts)
	);

endmodule

### src/pbtd_checker.sv
module pbtd_checker
	import pbtd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              dropped,
	input logic [TIME_W-1:0] start_ts
);

	// a dropped packet reports no start time
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> start_ts == '0)
		else $error("dropped item with nonzero start_ts");

	// one packet at a time: input closes right after an item is taken
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted item");

	// a new result only follows a packet in progress
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no packet in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dropped) && $stable(start_ts))
		else $error("stalled result changed");

endmodule

bind packet_buffer_tail_drop_timing pbtd_checker u_pbtd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dropped   (dropped),
	.start_ts  (start_ts)
);
